/* sv/spirm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI register access master package
// Command codes and sequencer phase type.
// ----------------------------------------------------------------------------
package spirm_pkg;

    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_BURST = 2'd3;

    localparam logic [7:0] READ_FLAG = 8'h80;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_SETUP = 5'b00010,
        PH_LOW   = 5'b00100,
        PH_HIGH  = 5'b01000,
        PH_HOLD  = 5'b10000
    } t_phase;

endpackage

/* sv/spi_register_access_master.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI mode-0 register access master
// Each input word is one tick of the serial line and yields one result word
// with the line levels and any received byte. Every accepted word passes
// through the sequencer logic once and lands in an output register, so the
// block takes one word per clock when the result side keeps up; a bit on the
// wire spans two words (SCK low, SCK high). Ready drops only while a finished
// result word waits in the output register and the result side is stalled.
// User must write setup and hold counts via APB only while idle; not enforced.
// ----------------------------------------------------------------------------
module spi_register_access_master
    import spirm_pkg::*;
#(
    parameter int MAX_BURST = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [6:0]  i_reg_address,
    input  logic [7:0]  i_write_data,
    input  logic [4:0]  i_read_length,
    input  logic        i_miso,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_chip_select_n,
    output logic        o_serial_clock,
    output logic        o_mosi_level,
    output logic [7:0]  o_read_byte,
    output logic        o_read_valid,
    output logic        o_read_last,
    output logic        o_busy_res,
    output logic        o_rejected,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_phase      r_phase, n_phase, v_phase;
    logic [1:0]  r_access_kind, n_access_kind;
    logic [2:0]  r_bit_count, n_bit_count;
    logic [4:0]  r_bytes_left, n_bytes_left;
    logic [7:0]  r_out_shift, n_out_shift;
    logic [7:0]  r_in_shift, n_in_shift;
    logic [9:0]  r_wait_count, n_wait_count;
    logic        r_address_phase, n_address_phase;
    logic [7:0]  r_data_hold, n_data_hold;
    logic [9:0]  r_setup_ticks, r_hold_ticks;

    logic        r_out_valid;
    logic        r_cs_n, r_sck, r_mosi, r_rvalid, r_rlast, r_busy, r_rej;
    logic [7:0]  r_rbyte;

    logic        cs_n, sck, mosi, rvalid, rlast, busy, rej;
    logic [7:0]  rbyte;
    logic [4:0]  v_len;
    logic        in_fire, cfg_wr;

    assign in_fire    = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign pready     = 1'b1;
    assign prdata     = paddr[2] ? {22'd0, r_hold_ticks} : {22'd0, r_setup_ticks};

    always_comb begin
        n_phase         = r_phase;
        n_access_kind   = r_access_kind;
        n_bit_count     = r_bit_count;
        n_bytes_left    = r_bytes_left;
        n_out_shift     = r_out_shift;
        n_in_shift      = r_in_shift;
        n_wait_count    = r_wait_count;
        n_address_phase = r_address_phase;
        n_data_hold     = r_data_hold;
        cs_n   = 1'b0;
        sck    = 1'b0;
        mosi   = 1'b0;
        busy   = 1'b1;
        rbyte  = 8'd0;
        rvalid = 1'b0;
        rlast  = 1'b0;
        rej    = 1'b0;
        v_len  = (i_read_length == 5'd0) ? 5'd1 : i_read_length;
        if ({3'd0, v_len} > 8'(MAX_BURST)) begin
            v_len = 5'(MAX_BURST);
        end

        if (r_phase == PH_IDLE) begin
            if (i_command != CMD_NONE) begin
                n_access_kind   = i_command;
                n_address_phase = 1'b1;
                n_bit_count     = 3'd0;
                n_in_shift      = 8'd0;
                n_data_hold     = i_write_data;
                n_out_shift     = (i_command == CMD_WRITE) ? {1'b0, i_reg_address}
                                                           : ({1'b0, i_reg_address} | READ_FLAG);
                if (i_command == CMD_BURST) begin
                    n_bytes_left = v_len;
                    n_phase      = PH_LOW;
                end else begin
                    n_bytes_left = 5'd1;
                    if (r_setup_ticks != 10'd0) begin
                        n_wait_count = r_setup_ticks;
                        n_phase      = PH_SETUP;
                    end else begin
                        n_phase = PH_LOW;
                    end
                end
            end
        end else if (i_command != CMD_NONE) begin
            rej = 1'b1;
        end

        v_phase = n_phase;
        case (v_phase)
            PH_SETUP, PH_HOLD: begin
                n_wait_count = n_wait_count - 10'd1;
                if (n_wait_count == 10'd0) begin
                    n_phase = (v_phase == PH_SETUP) ? PH_LOW : PH_IDLE;
                end
            end
            PH_LOW: begin
                mosi    = n_out_shift[7];
                n_phase = PH_HIGH;
            end
            PH_HIGH: begin
                sck         = 1'b1;
                mosi        = n_out_shift[7];
                n_in_shift  = {n_in_shift[6:0], i_miso};
                n_out_shift = {n_out_shift[6:0], 1'b0};
                n_bit_count = n_bit_count + 3'd1;
                n_phase     = PH_LOW;
                if (n_bit_count == 3'd0) begin
                    if (n_address_phase) begin
                        n_address_phase = 1'b0;
                        n_out_shift = (n_access_kind == CMD_WRITE) ? n_data_hold : 8'd0;
                        n_in_shift  = 8'd0;
                    end else begin
                        if (n_access_kind != CMD_WRITE) begin
                            rbyte  = n_in_shift;
                            rvalid = 1'b1;
                        end
                        n_bytes_left = (n_bytes_left != 5'd0) ? n_bytes_left - 5'd1 : 5'd0;
                        n_in_shift   = 8'd0;
                        n_out_shift  = 8'd0;
                        if (n_bytes_left == 5'd0) begin
                            rlast = rvalid;
                            if (n_access_kind == CMD_BURST) begin
                                n_phase = PH_IDLE;
                            end else if (r_hold_ticks != 10'd0) begin
                                n_wait_count = r_hold_ticks;
                                n_phase      = PH_HOLD;
                            end else begin
                                n_phase = PH_IDLE;
                            end
                        end
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
                cs_n    = 1'b1;
                busy    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_access_kind   <= CMD_NONE;
            r_bit_count     <= 3'd0;
            r_bytes_left    <= 5'd0;
            r_out_shift     <= 8'd0;
            r_in_shift      <= 8'd0;
            r_wait_count    <= 10'd0;
            r_address_phase <= 1'b0;
            r_data_hold     <= 8'd0;
        end else if (in_fire) begin
            r_phase         <= n_phase;
            r_access_kind   <= n_access_kind;
            r_bit_count     <= n_bit_count;
            r_bytes_left    <= n_bytes_left;
            r_out_shift     <= n_out_shift;
            r_in_shift      <= n_in_shift;
            r_wait_count    <= n_wait_count;
            r_address_phase <= n_address_phase;
            r_data_hold     <= n_data_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setup_ticks <= 10'd2;
            r_hold_ticks  <= 10'd170;
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                r_hold_ticks <= pwdata[9:0];
            end else begin
                r_setup_ticks <= pwdata[9:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cs_n   <= cs_n;
            r_sck    <= sck;
            r_mosi   <= mosi;
            r_rbyte  <= rbyte;
            r_rvalid <= rvalid;
            r_rlast  <= rlast;
            r_busy   <= busy;
            r_rej    <= rej;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_chip_select_n = r_cs_n;
    assign o_serial_clock  = r_sck;
    assign o_mosi_level    = r_mosi;
    assign o_read_byte     = r_rbyte;
    assign o_read_valid    = r_rvalid;
    assign o_read_last     = r_rlast;
    assign o_busy_res      = r_busy;
    assign o_rejected      = r_rej;

endmodule

/* sv/spirm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI register access master checker
// Port-level properties of the result words, bound to the top level.
// ----------------------------------------------------------------------------
module spirm_checker
    import spirm_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_chip_select_n,
    input logic        o_serial_clock,
    input logic [7:0]  o_read_byte,
    input logic        o_read_valid,
    input logic        o_read_last,
    input logic        o_busy_res,
    input logic        o_rejected
);

    a_reject_only_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rejected |-> o_busy_res)
        else $error("rejected word while idle");

    a_idle_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_busy_res |-> o_chip_select_n && !o_serial_clock)
        else $error("idle word drives bus lines");

    a_read_in_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_read_valid |-> !o_chip_select_n && o_serial_clock)
        else $error("read byte outside a high SCK half");

    a_last_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_read_last |-> o_read_valid)
        else $error("read_last without read_valid");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_byte))
        else $error("stalled result word changed");

endmodule

bind spi_register_access_master spirm_checker u_spirm_checker (.*);
